FILE: rtl/piecewise_linear_time_warp_lookup_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the time warp lookup
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TIME_WARP_LOOKUP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_TIME_WARP_LOOKUP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLWT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/plwt_pkg.sv
// ----------------------------------------------------------------------------
// Time warp lookup package
// Types and fixed constants shared by the front end, the engine and the top.
// ----------------------------------------------------------------------------
package plwt_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic signed [35:0] RES_MAX = 36'sh0_7FFF_FFFF;
	localparam logic signed [35:0] RES_MIN = 36'shF_8000_0000;

	typedef struct packed {
		logic        op;
		logic        drop;
		logic [5:0]  idx;
		logic [31:0] a;
		logic [31:0] b;
	} item_t;

	typedef struct packed {
		logic [31:0] sample;
		logic [31:0] warped;
	} point_t;

endpackage

FILE: rtl/plwt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plwt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/plwt_front.sv
// ----------------------------------------------------------------------------
// Time warp lookup front end
// Accepts items, marks loads to slots beyond the table, and queues them.
// ----------------------------------------------------------------------------
module plwt_front #(
	parameter int MAX_POINTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  operation,
	input  logic [5:0]            point_index,
	input  logic [31:0]           point_sample_time,
	input  logic [31:0]           point_warped_time,
	input  logic [31:0]           query_time,
	output logic                  head_valid,
	output plwt_pkg::item_t       head,
	input  logic                  head_take
);

	plwt_pkg::item_t entry_q [2];
	plwt_pkg::item_t in_item;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	always_comb begin
		in_item.op   = operation;
		in_item.idx  = point_index;
		in_item.drop = (operation == plwt_pkg::OP_LOAD) &&
			(int'({26'd0, point_index}) >= MAX_POINTS);
		in_item.a    = (operation == plwt_pkg::OP_QUERY) ? query_time : point_sample_time;
		in_item.b    = point_warped_time;
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = head_take && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

FILE: rtl/plwt_back.sv
// ----------------------------------------------------------------------------
// Time warp lookup engine
// Writes breakpoints, runs the binary search, interpolation and division.
// ----------------------------------------------------------------------------
`include "piecewise_linear_time_warp_lookup_top_macros.svh"

module plwt_back #(
	parameter int MAX_POINTS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [6:0]      cfg_wr_data,
	input  logic            head_valid,
	input  plwt_pkg::item_t head,
	output logic            head_take,
	output logic            empty,
	input  logic            pop,
	output logic [31:0]     mapped_time,
	output logic            saturated
);

	localparam int IW = $clog2(MAX_POINTS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PROBE = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_LO    = 3'd3;
	localparam logic [2:0] S_HI    = 3'd4;
	localparam logic [2:0] S_MUL   = 3'd5;
	localparam logic [2:0] S_DIV   = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0]          state_q;
	logic [6:0]          count_cfg_q;
	int                  n_int;
	logic [IW-1:0]       nm1;
	logic [IW-1:0]       nm1_q;
	logic [IW-1:0]       lo_q;
	logic [IW-1:0]       hi_q;
	logic [IW-1:0]       mid_q;
	logic [IW:0]         mid_sum;
	logic [IW-1:0]       mid;
	logic signed [31:0]  q_q;
	logic signed [31:0]  s_q;
	logic signed [31:0]  w_q;
	logic signed [35:0]  r_q;
	logic [31:0]         mdw_q;
	logic [31:0]         mdq_q;
	logic [31:0]         dsr_q;
	logic                neg_q;
	logic [63:0]         dvd_q;
	logic [31:0]         rem_q;
	logic [4:0]          dcnt_q;
	logic                out_valid_q;
	logic [31:0]         out_time_q;
	logic                out_sat_q;
	plwt_pkg::point_t    rdata;
	plwt_pkg::point_t    wdata;
	logic [IW-1:0]       raddr;
	logic                ram_we;
	logic signed [31:0]  rd_s;
	logic signed [31:0]  rd_w;
	logic signed [32:0]  dw;
	logic signed [32:0]  dq;
	logic signed [32:0]  ds;
	logic [32:0]         dw_mag;
	logic [32:0]         dq_mag;
	logic [32:0]         ds_mag;
	logic [32:0]         t1;
	logic [32:0]         t2;
	logic [32:0]         r1;
	logic [32:0]         r2;
	logic                ge1;
	logic                ge2;
	logic [34:0]         qclip;
	logic signed [35:0]  qsigned;
	logic                out_free;
	logic                out_load;

	always_comb begin
		n_int = int'(count_cfg_q);
		if (n_int == 0) begin
			n_int = 1;
		end
		if (n_int > MAX_POINTS) begin
			n_int = MAX_POINTS;
		end
		nm1 = IW'(n_int - 1);
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (IW+1)'(1);
	assign mid     = mid_sum[IW:1];
	assign rd_s    = signed'(rdata.sample);
	assign rd_w    = signed'(rdata.warped);

	assign dw     = 33'(rd_w) - 33'(w_q);
	assign dq     = 33'(q_q) - 33'(s_q);
	assign ds     = 33'(rd_s) - 33'(s_q);
	assign dw_mag = dw[32] ? 33'(-dw) : 33'(dw);
	assign dq_mag = dq[32] ? 33'(-dq) : 33'(dq);
	assign ds_mag = ds[32] ? 33'(-ds) : 33'(ds);

	assign t1  = {rem_q, dvd_q[63]};
	assign ge1 = (t1 >= {1'b0, dsr_q});
	assign r1  = ge1 ? (t1 - {1'b0, dsr_q}) : t1;
	assign t2  = {r1[31:0], dvd_q[62]};
	assign ge2 = (t2 >= {1'b0, dsr_q});
	assign r2  = ge2 ? (t2 - {1'b0, dsr_q}) : t2;

	always_comb begin
		if ((|dvd_q[63:35]) || (dvd_q[34] && (|dvd_q[33:0]))) begin
			qclip = 35'h4_0000_0000;
		end else begin
			qclip = dvd_q[34:0];
		end
		qsigned = neg_q ? -signed'({1'b0, qclip}) : signed'({1'b0, qclip});
	end

	assign out_free  = !out_valid_q || pop;
	assign out_load  = out_free && state_q == S_FIN && dcnt_q != 5'd31;
	assign head_take = (state_q == S_IDLE) && head_valid;
	assign ram_we    = head_take && (head.op == plwt_pkg::OP_LOAD) && !head.drop;
	assign wdata     = '{sample: head.a, warped: head.b};

	always_comb begin
		raddr = lo_q;
		case (state_q)
			S_PROBE: raddr = (lo_q < hi_q) ? mid : lo_q;
			S_LO:    raddr = lo_q + IW'(1);
			default: raddr = lo_q;
		endcase
	end

	plwt_ram #(
		.WIDTH($bits(plwt_pkg::point_t)),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IW'(head.idx)),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				q_q   <= signed'(head.a);
				nm1_q <= nm1;
			end
			S_PROBE: begin
				mid_q <= mid;
			end
			S_LO: begin
				s_q <= rd_s;
				w_q <= rd_w;
				if ((lo_q == '0 && q_q < rd_s) || (lo_q == nm1_q && q_q > rd_s)) begin
					r_q <= 36'(q_q) + 36'(rd_w) - 36'(rd_s);
				end else begin
					r_q <= 36'(rd_w);
				end
			end
			S_HI: begin
				mdw_q <= dw_mag[31:0];
				mdq_q <= dq_mag[31:0];
				dsr_q <= ds_mag[31:0];
				neg_q <= dw[32] ^ dq[32] ^ ds[32];
			end
			S_MUL: begin
				dvd_q <= mdw_q * mdq_q;
				rem_q <= '0;
			end
			S_DIV: begin
				dvd_q <= {dvd_q[61:0], ge1, ge2};
				rem_q <= r2[31:0];
			end
			S_FIN: begin
				if (state_q == S_FIN && dcnt_q == 5'd31) begin
					r_q <= qsigned + 36'(w_q);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			if (r_q > plwt_pkg::RES_MAX) begin
				out_time_q <= plwt_pkg::RES_MAX[31:0];
				out_sat_q  <= 1'b1;
			end else if (r_q < plwt_pkg::RES_MIN) begin
				out_time_q <= plwt_pkg::RES_MIN[31:0];
				out_sat_q  <= 1'b1;
			end else begin
				out_time_q <= r_q[31:0];
				out_sat_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_cfg_q <= 7'd1;
			lo_q        <= '0;
			hi_q        <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				count_cfg_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					dcnt_q <= '0;
					if (head_valid && head.op == plwt_pkg::OP_QUERY) begin
						lo_q    <= '0;
						hi_q    <= nm1;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= (lo_q < hi_q) ? S_CMP : S_LO;
				end
				S_CMP: begin
					if (rd_s <= q_q) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q - IW'(1);
					end
					state_q <= S_PROBE;
				end
				S_LO: begin
					if (lo_q < nm1_q && rd_s < q_q) begin
						state_q <= S_HI;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_HI: begin
					state_q <= (ds == '0) ? S_FIN : S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dcnt_q == 5'd31) begin
						state_q <= S_FIN;
					end else begin
						dcnt_q <= dcnt_q + 5'd1;
					end
				end
				S_FIN: begin
					if (dcnt_q == 5'd31) begin
						dcnt_q <= '0;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign empty       = !out_valid_q;
	assign mapped_time = out_time_q;
	assign saturated   = out_sat_q;

	`PLWT_ASSERT_NOW(a_div_nonzero, state_q == S_DIV, dsr_q != '0,
		"Division started with a zero divisor.")
	`PLWT_ASSERT_NOW(a_probe_order, state_q == S_PROBE || state_q == S_CMP, lo_q <= hi_q,
		"Search bounds crossed.")
	`PLWT_ASSERT_NOW(a_bound_in_table, state_q != S_IDLE, hi_q <= nm1_q,
		"Search bound beyond the last valid breakpoint.")
	`PLWT_ASSERT_NOW(a_sat_extreme, out_valid_q && out_sat_q,
		out_time_q == 32'h7FFF_FFFF || out_time_q == 32'h8000_0000,
		"Saturated result is not at a range limit.")

endmodule

FILE: rtl/piecewise_linear_time_warp_lookup_top.sv
// ----------------------------------------------------------------------------
// Piecewise-linear time warp lookup
// Breakpoint table with binary search and linear interpolation of Q16.16 times.
// ----------------------------------------------------------------------------
// Usage:
// Items enter through push/full; an item is taken when push is high and full
// is low. A load writes one breakpoint and gives no result; a query gives one.
// Results leave through empty/pop; the oldest result stays on mapped_time and
// saturated while empty is low and is taken when pop is high.
// point_count is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this. A
// two-entry input queue decouples intake from the engine, so items are still
// taken while a finished result waits for pop. A stalled receiver holds the
// engine at its final step; loads behind it wait in the queue. The engine writes
// a load to the table as it takes it while idle. A query runs up to
// log2(MAX_POINTS) search probes, and an interpolated query then adds the
// differences, a multiply and a radix-4 division.
// Breakpoints are read one at a time from a single table memory.
// Reset empties the queue and the result register and sets point_count to 1;
// the table holds undefined data until loaded.
// ----------------------------------------------------------------------------
module piecewise_linear_time_warp_lookup_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [5:0]  point_index,
	input  logic [31:0] point_sample_time,
	input  logic [31:0] point_warped_time,
	input  logic [31:0] query_time,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] mapped_time,
	output logic        saturated,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data
);

	logic            head_valid;
	logic            head_take;
	plwt_pkg::item_t head;

	plwt_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.operation         (operation),
		.point_index       (point_index),
		.point_sample_time (point_sample_time),
		.point_warped_time (point_warped_time),
		.query_time        (query_time),
		.head_valid        (head_valid),
		.head              (head),
		.head_take         (head_take)
	);

	plwt_back #(
		.MAX_POINTS(MAX_POINTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head_valid  (head_valid),
		.head        (head),
		.head_take   (head_take),
		.empty       (empty),
		.pop         (pop),
		.mapped_time (mapped_time),
		.saturated   (saturated)
	);

endmodule

FILE: sim/tb_piecewise_linear_time_warp_lookup_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the piecewise-linear time warp lookup
// Loads breakpoint tables (sorted, with repeated sample times, and unsorted),
// sweeps point_count across its range, and maps query times. Every query is
// predicted in the bench and compared with the result the block hands out.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_time_warp_lookup_top;

	localparam int NPTS = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 150;

	typedef struct {
		logic        op;
		logic [5:0]  idx;
		logic [31:0] s;
		logic [31:0] w;
		logic [31:0] qt;
	} txn_t;

	typedef struct {
		logic [31:0] mapped;
		logic        sat;
	} mapping_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        operation = 1'b0;
	logic [5:0]  point_index = '0;
	logic [31:0] point_sample_time = '0;
	logic [31:0] point_warped_time = '0;
	logic [31:0] query_time = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] mapped_time;
	logic        saturated;
	logic        cfg_wr_en = 1'b0;
	logic [6:0]  cfg_wr_data = '0;

	txn_t     pending_q[$];
	mapping_t mapping_q[$];
	logic signed [31:0] sample_tbl[NPTS];
	logic signed [31:0] warped_tbl[NPTS];
	logic [6:0] count_reg = 7'd1;
	bit   calm = 1'b0;
	int   errors = 0;
	int   cycles = 0;

	piecewise_linear_time_warp_lookup_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.point_index(point_index),
		.point_sample_time(point_sample_time),
		.point_warped_time(point_warped_time),
		.query_time(query_time),
		.empty(empty),
		.pop(pop),
		.mapped_time(mapped_time),
		.saturated(saturated),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(0) - v : v;
	endfunction

	function automatic mapping_t warp_time(logic [31:0] qt);
		mapping_t res;
		int n, lo, hi, mid;
		longint q, s, w, s1, w1, r, dw, dq, ds;
		longint unsigned prod, quo;
		bit neg;
		n = count_reg;
		if (n < 1) n = 1;
		if (n > NPTS) n = NPTS;
		q = longint'($signed(qt));
		lo = 0;
		hi = n - 1;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (longint'(sample_tbl[mid]) <= q) lo = mid;
			else hi = mid - 1;
		end
		s = sample_tbl[lo];
		w = warped_tbl[lo];
		r = w;
		if (lo == 0 && q < s) begin
			r = q + (w - s);
		end else if (lo < n - 1 && s < q) begin
			s1 = sample_tbl[lo + 1];
			w1 = warped_tbl[lo + 1];
			if (s1 != s) begin
				dw = w1 - w;
				dq = q - s;
				ds = s1 - s;
				prod = magnitude(dw) * magnitude(dq);
				quo = prod / magnitude(ds);
				neg = ((dw < 0) != (dq < 0)) != (ds < 0);
				if (quo > (64'd1 << 34)) quo = 64'd1 << 34;
				r = (neg ? -longint'(quo) : longint'(quo)) + w;
			end
		end else if (lo == n - 1 && q > s) begin
			r = q + (w - s);
		end
		res.sat = 1'b0;
		if (r > 64'sd2147483647) begin
			r = 64'sd2147483647;
			res.sat = 1'b1;
		end
		if (r < -64'sd2147483648) begin
			r = -64'sd2147483648;
			res.sat = 1'b1;
		end
		res.mapped = r[31:0];
		return res;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Sender: an accepted load updates the bench table, an accepted query
	// queues its expected mapping.
	int  send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		txn_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
			send_gap = 0;
		end else if (!(push && full)) begin
			if (push) begin
				if (operation == plwt_pkg::OP_LOAD) begin
					sample_tbl[point_index] = point_sample_time;
					warped_tbl[point_index] = point_warped_time;
				end else begin
					mapping_q = {mapping_q, warp_time(query_time)};
				end
			end
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (pending_q.size() > 0 && !calm && $urandom_range(0, 4) == 0) begin
				send_gap = $urandom_range(0, 2);
				push <= 1'b0;
			end else if (pending_q.size() > 0) begin
				nxt = pending_q.pop_front();
				push <= 1'b1;
				operation <= nxt.op;
				point_index <= nxt.idx;
				point_sample_time <= nxt.s;
				point_warped_time <= nxt.w;
				query_time <= nxt.qt;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: checks each transaction against the oldest expected mapping.
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		mapping_t exp_map;
		if (!arst_n) begin
			pop <= 1'b0;
			recv_gap = 0;
		end else begin
			if (pop && !empty) begin
				if (mapping_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Unexpected result: mapped_time=%h saturated=%b",
							mapped_time, saturated);
				end else begin
					exp_map = mapping_q.pop_front();
					if (mapped_time !== exp_map.mapped || saturated !== exp_map.sat) begin
						errors++;
						if (errors <= 10)
							$display("Mismatch: expected %h/%b, got %h/%b",
								exp_map.mapped, exp_map.sat, mapped_time, saturated);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				recv_gap = $urandom_range(0, 2);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic add_load(int idx, logic [31:0] s, logic [31:0] w);
		txn_t t;
		t.op = plwt_pkg::OP_LOAD;
		t.idx = idx[5:0];
		t.s = s;
		t.w = w;
		t.qt = $urandom;
		pending_q = {pending_q, t};
	endtask

	task automatic add_query(logic [31:0] qt);
		txn_t t;
		t.op = plwt_pkg::OP_QUERY;
		t.idx = 6'($urandom);
		t.s = $urandom;
		t.w = $urandom;
		t.qt = qt;
		pending_q = {pending_q, t};
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() != 0 || push || mapping_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(logic [6:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		count_reg = v;
	endtask

	// Style 0 is sorted, 1 sorted with repeated sample times, 2 unsorted.
	task automatic build_table(int style, int n);
		int st[NPTS];
		foreach (st[i]) st[i] = $urandom;
		if (style != 2) st.sort();
		if (style == 1)
			for (int i = 1; i < NPTS; i++)
				if ($urandom_range(0, 3) == 0) st[i] = st[i - 1];
		for (int i = 0; i < n; i++)
			add_load(i, st[i], ($urandom_range(0, 1) == 0) ? $urandom :
				st[i] + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
	endtask

	initial begin
		int cnt_choice[8] = '{64, 1, 0, 127, 2, 33, 50, 65};
		int n, k;
		logic [31:0] bp;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NPTS; i++)
			add_load(i, (i - 32) << 20, ((i - 32) << 20) + i * 32'h1000);
		drain();
		set_count(7'd1);
		add_query(32'h8000_0000);
		add_query(32'h7FFF_FFFF);
		add_query(32'h0000_0000);
		drain();
		set_count(7'd64);
		add_query(32'h8000_0000);
		add_query(32'h7FFF_FFFF);
		add_query((5 - 32) << 20);
		add_query(((5 - 32) << 20) + 32'h0008_1234);
		add_query(32'hFE00_0000);
		add_query(32'h01F0_0000);
		add_load(63, 32'h01F0_0000, 32'h7FFF_0000);
		add_load(0, 32'hFE00_0000, 32'h8000_1000);
		add_query(32'h7FFF_FFFF);
		add_query(32'h8000_0000);
		add_load(62, 32'h01E0_0000, 32'h8000_0000);
		add_query(32'h01E8_0000);
		add_query(32'h01F0_0000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 3 || ph == 7);
			n = cnt_choice[ph];
			if (n < 1) n = 1;
			if (n > NPTS) n = NPTS;
			build_table(ph % 3, n);
			drain();
			set_count(7'(cnt_choice[ph]));
			for (int j = 0; j < 20; j++) begin
				k = $urandom_range(0, n - 1);
				bp = sample_tbl[k];
				if ($urandom_range(0, 6) == 0) begin
					add_load(k, $urandom, $urandom);
				end else begin
					case ($urandom_range(0, 4))
						0, 1: add_query($urandom);
						2, 3: add_query(bp + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
						default: add_query(bp);
					endcase
				end
				if (ph == 2 && j == 10) drain();
			end
			drain();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: piecewise_linear_time_warp_lookup_top.f
+incdir+rtl
rtl/plwt_pkg.sv
rtl/plwt_ram.sv
rtl/plwt_front.sv
rtl/plwt_back.sv
rtl/piecewise_linear_time_warp_lookup_top.sv
sim/tb_piecewise_linear_time_warp_lookup_top.sv
